### hdl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and the arctangent table of the Euler-angle to
// quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package e2q_pkg;

  localparam int unsigned CordicStepsDflt = 16;
  localparam int unsigned AngleBitsDflt   = 16;
  localparam int unsigned AtanEntries     = 30;
  localparam int unsigned XyW             = 34;
  localparam logic signed [XyW-1:0] CordicGainQ30 = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } out_beat_t;

  // atan(2^-i) with pi = 2^31.
  function automatic logic [31:0] atan_raw(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'd536870912;
      5'd1:  t = 32'd316933406;
      5'd2:  t = 32'd167458907;
      5'd3:  t = 32'd85004756;
      5'd4:  t = 32'd42667331;
      5'd5:  t = 32'd21354465;
      5'd6:  t = 32'd10679838;
      5'd7:  t = 32'd5340245;
      5'd8:  t = 32'd2670163;
      5'd9:  t = 32'd1335087;
      5'd10: t = 32'd667544;
      5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;
      5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;
      5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;
      5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;
      5'd19: t = 32'd1304;
      5'd20: t = 32'd652;
      5'd21: t = 32'd326;
      5'd22: t = 32'd163;
      5'd23: t = 32'd81;
      5'd24: t = 32'd41;
      5'd25: t = 32'd20;
      5'd26: t = 32'd10;
      5'd27: t = 32'd5;
      5'd28: t = 32'd3;
      5'd29: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

### hdl/e2q_cordic_stage.sv
// ----------------------------------------------------------------------------
// e2q_cordic_stage
// One registered rotation-mode CORDIC iteration for three angles at once.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_cordic_stage #(
  parameter int unsigned Step      = 0,
  parameter int unsigned AngleBits = e2q_pkg::AngleBitsDflt
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [e2q_pkg::XyW-1:0] x_i [3],
  input  wire logic signed [e2q_pkg::XyW-1:0] y_i [3],
  input  wire logic signed [AngleBits+1:0]    z_i [3],
  output logic signed [e2q_pkg::XyW-1:0]      x_o [3],
  output logic signed [e2q_pkg::XyW-1:0]      y_o [3],
  output logic signed [AngleBits+1:0]         z_o [3]
);

  localparam int unsigned ZW = AngleBits + 2;

  // Arctangent brought to the accumulator scale, worked out at elaboration.
  function automatic logic signed [ZW-1:0] atan_scaled();
    longint t;
    t = longint'(e2q_pkg::atan_raw(5'(Step)));
    if (AngleBits >= 31) t = t <<< (AngleBits - 31);
    else t = (t + (longint'(1) <<< (30 - AngleBits))) >>> (31 - AngleBits);
    return ZW'(t);
  endfunction

  localparam logic signed [ZW-1:0] Atan = atan_scaled();

  logic signed [e2q_pkg::XyW-1:0] x_d [3];
  logic signed [e2q_pkg::XyW-1:0] y_d [3];
  logic signed [ZW-1:0]           z_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!z_i[k][ZW-1]) begin
        x_d[k] = x_i[k] - (y_i[k] >>> Step);
        y_d[k] = y_i[k] + (x_i[k] >>> Step);
        z_d[k] = z_i[k] - Atan;
      end else begin
        x_d[k] = x_i[k] + (y_i[k] >>> Step);
        y_d[k] = y_i[k] - (x_i[k] >>> Step);
        z_d[k] = z_i[k] + Atan;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end

endmodule

`default_nettype wire

### hdl/e2q_products.sv
// ----------------------------------------------------------------------------
// e2q_products
// Three-stage product and combine pipeline: pair products, triple products,
// then sums, rounding and saturation to Q1.15.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_products (
  input  wire logic                           clk_i,
  input  wire logic [2:0]                     en_i,
  input  wire logic signed [e2q_pkg::XyW-1:0] c_i [3],
  input  wire logic signed [e2q_pkg::XyW-1:0] s_i [3],
  output e2q_pkg::out_beat_t                  q_o
);

  localparam int unsigned W = e2q_pkg::XyW;

  // Pair products of roll and pitch terms: cc, sc, cs, ss (roll first).
  logic signed [W-1:0] pr_q [4];
  logic signed [W-1:0] cy_q, sy_q;
  // Triple products: ccc sss scc css csc scs ccs ssc.
  logic signed [2*W-1:0] tp_q [8];

  function automatic logic signed [W-1:0] rmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    p = a * b + (64'sd1 <<< 29);
    return W'(p >>> 30);
  endfunction

  function automatic logic signed [15:0] q15(input logic signed [2*W-1:0] a,
                                             input logic signed [2*W-1:0] b,
                                             input logic sub);
    logic signed [2*W:0] v;
    logic signed [2*W:0] r;
    v = sub ? ((2*W+1)'(a) - (2*W+1)'(b)) : ((2*W+1)'(a) + (2*W+1)'(b));
    r = (v + ((2*W+1)'(1) <<< 44)) >>> 45;
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return 16'sh8000;
    return r[15:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pr_q[0] <= rmul(c_i[0], c_i[1]);
      pr_q[1] <= rmul(s_i[0], c_i[1]);
      pr_q[2] <= rmul(c_i[0], s_i[1]);
      pr_q[3] <= rmul(s_i[0], s_i[1]);
      cy_q    <= c_i[2];
      sy_q    <= s_i[2];
    end
    if (en_i[1]) begin
      tp_q[0] <= pr_q[0] * cy_q;
      tp_q[1] <= pr_q[3] * sy_q;
      tp_q[2] <= pr_q[1] * cy_q;
      tp_q[3] <= pr_q[2] * sy_q;
      tp_q[4] <= pr_q[2] * cy_q;
      tp_q[5] <= pr_q[1] * sy_q;
      tp_q[6] <= pr_q[0] * sy_q;
      tp_q[7] <= pr_q[3] * cy_q;
    end
    if (en_i[2]) begin
      q_o.quat_w <= q15(tp_q[0], tp_q[1], 1'b0);
      q_o.quat_x <= q15(tp_q[2], tp_q[3], 1'b1);
      q_o.quat_y <= q15(tp_q[4], tp_q[5], 1'b0);
      q_o.quat_z <= q15(tp_q[6], tp_q[7], 1'b1);
    end
  end

endmodule

`default_nettype wire

### hdl/euler_to_quaternion_unit.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// ZYX Euler angles to unit quaternion through pipelined CORDIC and products.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output is not stalled; each
// CORDIC iteration and each multiply level owns a register stage, so a
// new beat enters every cycle unless the output stalls.
// Reset clears only the stage valid bits; data registers are not reset.
// A stall freezes the last stage and the full stages right behind it.
`default_nettype none

module euler_to_quaternion_unit #(
  parameter int unsigned CORDIC_STEPS = e2q_pkg::CordicStepsDflt,
  parameter int unsigned ANGLE_BITS   = e2q_pkg::AngleBitsDflt
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire e2q_pkg::in_beat_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output e2q_pkg::out_beat_t      out_data_o
);

  localparam int unsigned Steps = (CORDIC_STEPS < e2q_pkg::AtanEntries) ?
                                  CORDIC_STEPS : e2q_pkg::AtanEntries;
  localparam int unsigned ZW    = ANGLE_BITS + 2;
  localparam int unsigned W     = e2q_pkg::XyW;
  // Stage 0 is the angle entry register; then Steps CORDIC stages; then
  // three product stages, the last of which is the output register.
  localparam int unsigned NStg  = Steps + 4;

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] en;

  // Valid bits travel with the data. A stage advances when it is empty or
  // its successor can take a beat; the output stage when empty or taken.
  always_comb begin
    en[NStg-1] = !vld_q[NStg-1] || out_ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Half angle onto the accumulator scale: a * 2^(ANGLE_BITS-16).
  function automatic logic signed [ZW-1:0] half_angle(input logic signed [15:0] a);
    logic signed [ZW+15:0] t;
    t = (ZW+16)'(a);
    if (ANGLE_BITS >= 16) t = t <<< (ANGLE_BITS - 16);
    else t = t >>> (16 - ANGLE_BITS);
    return t[ZW-1:0];
  endfunction

  logic signed [W-1:0]  x_s [Steps+1][3];
  logic signed [W-1:0]  y_s [Steps+1][3];
  logic signed [ZW-1:0] z_s [Steps+1][3];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        x_s[0][k] <= e2q_pkg::CordicGainQ30;
        y_s[0][k] <= '0;
      end
      z_s[0][0] <= half_angle(in_data_i.roll_angle);
      z_s[0][1] <= half_angle(in_data_i.pitch_angle);
      z_s[0][2] <= half_angle(in_data_i.yaw_angle);
    end
  end

  for (genvar g = 0; g < Steps; g++) begin : g_cordic
    e2q_cordic_stage #(
      .Step      (g),
      .AngleBits (ANGLE_BITS)
    ) u_stage (
      .clk_i (clk_i),
      .en_i  (en[g+1]),
      .x_i   (x_s[g]),
      .y_i   (y_s[g]),
      .z_i   (z_s[g]),
      .x_o   (x_s[g+1]),
      .y_o   (y_s[g+1]),
      .z_o   (z_s[g+1])
    );
  end

  // Final x is the cosine and y the sine of each half angle.
  e2q_products u_products (
    .clk_i (clk_i),
    .en_i  (en[NStg-1:NStg-3]),
    .c_i   (x_s[Steps]),
    .s_i   (y_s[Steps]),
    .q_o   (out_data_o)
  );

  // A stalled output beat is held by the frozen last stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped during stall");
  // Entry refuses a beat only when the pipeline is full back to front.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");
  // A stall freezes the valid pattern.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q) || $past(out_ready_i))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

### test/euler_to_quaternion_unit_tb.sv
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit_tb
// Drives roll, pitch and yaw beats into the Euler-angle to quaternion unit
// with random gaps and output stalls. A bit-exact CORDIC and product model
// predicts each quaternion, and a scoreboard compares results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_quaternion_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Steps     = e2q_pkg::CordicStepsDflt;
  localparam int unsigned ABits     = e2q_pkg::AngleBitsDflt;
  localparam int unsigned NumRandom = 930;
  localparam int unsigned Latency   = ((Steps < 30) ? Steps : 30) + 4;
  localparam int unsigned IdleLimit = 2000;

  // Floor shift right of a signed 64-bit value.
  function automatic longint floor_shr(input longint v, input int unsigned s);
    return v >>> s;
  endfunction

  // Table of atan(2^-i) with pi = 2^31, kept apart from the package.
  function automatic longint atan_tab_entry(input int unsigned i);
    longint tab [30];
    tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
            41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
            10, 5, 3, 1};
    return tab[i];
  endfunction

  // Arctangent of entry i brought to the accumulator scale.
  function automatic longint atan_step(input int unsigned i);
    longint t;
    t = atan_tab_entry(i);
    if (ABits >= 31) return t <<< (ABits - 31);
    return floor_shr(t + (64'sd1 <<< (30 - ABits)), 31 - ABits);
  endfunction

  // Cosine and sine of half the binary angle, both Q2.30.
  task automatic half_angle_cos_sin(input logic signed [15:0] ang,
                                    output longint c, output longint s);
    longint z, x, y, dx, dy;
    x = 652032874;
    y = 0;
    if (ABits >= 16) z = longint'(ang) <<< (ABits - 16);
    else z = floor_shr(longint'(ang), 16 - ABits);
    for (int unsigned i = 0; i < Steps && i < 30; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_step(i);
      end else begin
        x = x + dx; y = y - dy; z = z + atan_step(i);
      end
    end
    c = x;
    s = y;
  endtask

  function automatic longint prod3(input longint a, input longint b, input longint c);
    longint ab;
    ab = floor_shr(a * b + (64'sd1 <<< 29), 30);
    return ab * c;
  endfunction

  function automatic logic signed [15:0] sat_q15(input longint v);
    longint r;
    r = floor_shr(v + (64'sd1 <<< 44), 45);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic predict_quaternion(input e2q_pkg::in_beat_t a,
                                    output e2q_pkg::out_beat_t q);
    longint cr, sr, cp, sp, cy, sy;
    half_angle_cos_sin(a.roll_angle, cr, sr);
    half_angle_cos_sin(a.pitch_angle, cp, sp);
    half_angle_cos_sin(a.yaw_angle, cy, sy);
    q.quat_w = sat_q15(prod3(cr, cp, cy) + prod3(sr, sp, sy));
    q.quat_x = sat_q15(prod3(sr, cp, cy) - prod3(cr, sp, sy));
    q.quat_y = sat_q15(prod3(cr, sp, cy) + prod3(sr, cp, sy));
    q.quat_z = sat_q15(prod3(cr, cp, sy) - prod3(sr, sp, cy));
  endtask

  int unsigned mismatches = 0;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Holds the quaternions still owed by the unit, oldest first.
  class quat_scoreboard;
    e2q_pkg::out_beat_t pending_quats[$];

    task note_angles(e2q_pkg::in_beat_t a);
      e2q_pkg::out_beat_t q;
      predict_quaternion(a, q);
      pending_quats.push_back(q);
    endtask

    task check_quat(e2q_pkg::out_beat_t got);
      e2q_pkg::out_beat_t want;
      if (pending_quats.size() == 0) begin
        report($sformatf("unexpected quaternion %p", got));
        return;
      end
      want = pending_quats.pop_front();
      if (got.quat_w !== want.quat_w)
        report($sformatf("w got %0d want %0d", got.quat_w, want.quat_w));
      if (got.quat_x !== want.quat_x)
        report($sformatf("x got %0d want %0d", got.quat_x, want.quat_x));
      if (got.quat_y !== want.quat_y)
        report($sformatf("y got %0d want %0d", got.quat_y, want.quat_y));
      if (got.quat_z !== want.quat_z)
        report($sformatf("z got %0d want %0d", got.quat_z, want.quat_z));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  e2q_pkg::in_beat_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  e2q_pkg::out_beat_t out_data_o;

  quat_scoreboard sb = new();
  bit        no_stall = 1'b0;
  int unsigned idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  euler_to_quaternion_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Accepted beats are sampled at the rising edge, before the driver's
  // nonblocking updates land, so the order of processes does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_angles(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_quat(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: a fresh stall length per beat, with some stretches of none.
  initial begin
    int unsigned wait_cycles;
    @(posedge rst_ni);
    forever begin
      wait_cycles = no_stall ? 0 : $urandom_range(0, 5);
      repeat (wait_cycles) begin
        @(posedge clk_i);
        out_ready_i <= 1'b0;
      end
      @(posedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o || !out_ready_i);
      // Lower ready in the following gap unless none follows; the
      // next loop pass either keeps it high or drops it once.
      if (!no_stall) out_ready_i <= 1'b0;
    end
  end

  // Sends one beat after a random gap; valid stays high until accepted.
  task automatic send_angles(input e2q_pkg::in_beat_t a, input bit gapless);
    int unsigned gap;
    gap = gapless ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(posedge clk_i);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= a;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic e2q_pkg::in_beat_t angles(input int r, input int p, input int y);
    e2q_pkg::in_beat_t a;
    a.roll_angle  = r[15:0];
    a.pitch_angle = p[15:0];
    a.yaw_angle   = y[15:0];
    return a;
  endfunction

  initial begin
    int edge_vals [7];
    int unsigned settle;
    e2q_pkg::in_beat_t a;
    edge_vals = '{-32768, 32767, 0, -1, 1, 16384, -16384};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each axis alone at the extremes, including minus pi whose
    // half angle sits on the edge of the CORDIC range, then mixed corners.
    send_angles(angles(0, 0, 0), 1'b0);
    for (int k = 0; k < 7; k++) begin
      send_angles(angles(edge_vals[k], 0, 0), 1'b0);
      send_angles(angles(0, edge_vals[k], 0), 1'b0);
      send_angles(angles(0, 0, edge_vals[k]), 1'b0);
    end
    send_angles(angles(-32768, -32768, -32768), 1'b0);
    send_angles(angles(32767, 32767, 32767), 1'b0);
    send_angles(angles(-32768, 32767, -1), 1'b0);

    // Random: alternate bursts with gaps and bursts running flat out.
    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n % 100 == 0) no_stall = ($urandom_range(0, 3) == 0);
      a = e2q_pkg::in_beat_t'({$urandom(), 16'($urandom())});
      if ($urandom_range(0, 7) == 0)
        a.pitch_angle = 16'(edge_vals[$urandom_range(0, 6)]);
      send_angles(a, no_stall);
    end
    in_valid_i <= 1'b0;
    no_stall = 1'b0;

    while (sb.pending_quats.size() != 0) @(posedge clk_i);
    settle = 0;
    while (settle < 4 * Latency) begin
      @(posedge clk_i);
      settle++;
    end
    if (mismatches == 0 && sb.pending_quats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
